>>> rtl/rfid_reply_frame_checker_defines.svh
// ----------------------------------------------------------------------------
// Reply frame checker assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RFID_REPLY_FRAME_CHECKER_DEFINES_SVH
`define RFID_REPLY_FRAME_CHECKER_DEFINES_SVH

// same-cycle implication
`define RRFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("reply frame checker assertion failed");

// next-cycle implication
`define RRFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("reply frame checker assertion failed");

`endif

>>> rtl/rrfc_pkg.sv
// ----------------------------------------------------------------------------
// Reply frame checker package
// Types, frame offsets and the byte-wide reflected CRC-16 step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rrfc_pkg;

    localparam int UID_BYTES = 8;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;

    localparam logic [8:0] COUNT_MAX   = 9'd511;
    localparam logic [8:0] OFS_LEN     = 9'd0;
    localparam logic [8:0] OFS_CMD     = 9'd2;
    localparam logic [8:0] OFS_STATUS  = 9'd3;
    localparam logic [8:0] OFS_DATA    = 9'd4;
    localparam logic [8:0] OFS_UID_END = 9'(4 + UID_BYTES);

    localparam logic CFG_EXPECTED_CMD   = 1'b0;
    localparam logic CFG_SUCCESS_STATUS = 1'b1;

    localparam logic [7:0] EXPECTED_CMD_RST   = 8'h50;
    localparam logic [7:0] SUCCESS_STATUS_RST = 8'h00;

    typedef enum logic [1:0] {
        ERR_OK  = 2'd0,
        ERR_CMD = 2'd1,
        ERR_CRC = 2'd2
    } t_err;

    typedef struct packed {
        logic       restart;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  frame_length;
        logic [63:0] tag_uid;
        logic        status_good;
        logic [7:0]  reader_status;
        t_err        error_code;
        logic        frame_ok;
    } t_verdict;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/rrfc_frame_state.sv
// ----------------------------------------------------------------------------
// Reply frame state
// Byte count, running CRC and captured fields; forms the verdict on the last byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rrfc_frame_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  rrfc_pkg::t_in_item i_item,
    input  logic [7:0]        i_expected_command,
    input  logic [7:0]        i_success_status,
    output logic              o_verdict_valid,
    output rrfc_pkg::t_verdict o_verdict
);
    import rrfc_pkg::*;

    logic [8:0]  r_count, n_count;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_cmd, n_cmd;
    logic [7:0]  r_status, n_status;
    logic [63:0] r_uid, n_uid;

    logic        stopped;
    logic        take;
    logic        hit;
    t_err        err;

    always_comb begin
        stopped  = r_count > {1'b0, r_len};
        take     = i_step && !i_item.restart && !stopped;

        n_crc    = crc_byte(r_crc, i_item.rx_byte);
        n_len    = (r_count == OFS_LEN)    ? i_item.rx_byte : r_len;
        n_cmd    = (r_count == OFS_CMD)    ? i_item.rx_byte : r_cmd;
        n_status = (r_count == OFS_STATUS) ? i_item.rx_byte : r_status;
        n_uid    = (r_count >= OFS_DATA && r_count < OFS_UID_END)
                   ? {r_uid[55:0], i_item.rx_byte} : r_uid;
        n_count  = (r_count < COUNT_MAX) ? r_count + 9'd1 : r_count;

        hit = n_count == ({1'b0, n_len} + 9'd1);

        if (n_cmd != i_expected_command) begin
            err = ERR_CMD;
        end else if (n_crc != 16'h0000) begin
            err = ERR_CRC;
        end else begin
            err = ERR_OK;
        end

        o_verdict_valid           = take && hit;
        o_verdict.frame_ok        = (err == ERR_OK);
        o_verdict.error_code      = err;
        o_verdict.reader_status   = n_status;
        o_verdict.status_good     = (err == ERR_OK) && (n_status == i_success_status);
        o_verdict.tag_uid         = n_uid;
        o_verdict.frame_length    = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.restart)) begin
            r_count  <= '0;
            r_len    <= '0;
            r_crc    <= CRC_PRESET;
            r_cmd    <= '0;
            r_status <= '0;
            r_uid    <= '0;
        end else if (take) begin
            r_count  <= n_count;
            r_len    <= n_len;
            r_crc    <= n_crc;
            r_cmd    <= n_cmd;
            r_status <= n_status;
            r_uid    <= n_uid;
        end
    end

endmodule

>>> rtl/rfid_reply_frame_checker.sv
// A verdict is registered in the output register after the frame's last byte leaves the input register.
// Throughput: one byte per cycle; the byte-wide CRC step between the frame state
// registers sets this, and a held verdict stalls the input only when the input
// register is also full.
// Reset (i_rst_n low, synchronous): frame state cleared, CRC preset, registers
// back to expected_command 0x50 and success_status 0x00, both stages empty.
// ----------------------------------------------------------------------------
// RFID reply frame checker
// Streams reply bytes through a CRC-16 frame check and emits at most one verdict per frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfid_reply_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] restart
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] frame_ok, [2:1] error_code, [10:3] reader_status, [11] status_good,
    // [75:12] tag_uid, [83:76] frame_length, [87:84] zero
    output logic [87:0] o_m_axis_tdata
);
    import rrfc_pkg::*;

    logic [7:0] r_expected_command;
    logic [7:0] r_success_status;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_verdict   r_out;

    logic       s_accept;
    logic       step;
    logic       verdict_valid;
    t_verdict   verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_command <= EXPECTED_CMD_RST;
            r_success_status   <= SUCCESS_STATUS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EXPECTED_CMD:   r_expected_command <= i_cfg_data;
                CFG_SUCCESS_STATUS: r_success_status   <= i_cfg_data;
                default:            r_expected_command <= r_expected_command;
            endcase
        end
    end

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_item.restart <= i_s_axis_tuser[0];
            r_in_item.rx_byte <= i_s_axis_tdata;
        end
    end

    rrfc_frame_state u_frame_state (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .i_item             (r_in_item),
        .i_expected_command (r_expected_command),
        .i_success_status   (r_success_status),
        .o_verdict_valid    (verdict_valid),
        .o_verdict          (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= verdict_valid;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && verdict_valid) begin
            r_out <= verdict;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out.frame_length, r_out.tag_uid, r_out.status_good,
                              r_out.reader_status, r_out.error_code, r_out.frame_ok};

endmodule

>>> rtl/rrfc_checker.sv
// ----------------------------------------------------------------------------
// Reply frame checker port assertions
// Watches the top-level ports for verdict consistency and output stability.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rfid_reply_frame_checker_defines.svh"

module rrfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [87:0] o_m_axis_tdata
);
    import rrfc_pkg::*;

    // stalled verdict holds
    `RRFC_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // ok flag agrees with error code
    `RRFC_ASSERT_NOW(a_ok_code, o_m_axis_tvalid, o_m_axis_tdata[0] == (o_m_axis_tdata[2:1] == ERR_OK))

    // only defined error codes appear
    `RRFC_ASSERT_NOW(a_code_set, o_m_axis_tvalid, o_m_axis_tdata[2:1] == ERR_OK || o_m_axis_tdata[2:1] == ERR_CMD || o_m_axis_tdata[2:1] == ERR_CRC)

    // good status only on a good frame
    `RRFC_ASSERT_NOW(a_good_ok, o_m_axis_tvalid && o_m_axis_tdata[11], o_m_axis_tdata[0])

    // input always ready while no verdict is held
    `RRFC_ASSERT_NOW(a_in_ready, !o_m_axis_tvalid, o_s_axis_tready)

endmodule

bind rfid_reply_frame_checker rrfc_checker u_rrfc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

>>> verif/rfid_reply_frame_checker_tb.sv
// ----------------------------------------------------------------------------
// RFID reply frame checker testbench
// Streams directed and random reply frames through the checker with bursty
// input and a stalling output, predicts every verdict with its own CRC-16 frame
// tracker and compares each output transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfid_reply_frame_checker_tb;
    import rrfc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 195;
    localparam int HOLD_CYCLES = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_EXPECTED_CMD;
    logic [7:0]  cfg_data = 8'h00;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;

    t_in_item pending_bytes[$];
    t_verdict expected_verdicts[$];

    // frame tracker and its copy of the registers
    logic [8:0]  fr_count;
    logic [7:0]  fr_len;
    logic [15:0] fr_crc;
    logic [7:0]  fr_cmd;
    logic [7:0]  fr_status;
    logic [63:0] fr_uid;
    logic [7:0]  cfg_cmd;
    logic [7:0]  cfg_status;

    // register values the frame generator builds against
    logic [7:0]  gen_cmd = EXPECTED_CMD_RST;
    logic [7:0]  gen_status = SUCCESS_STATUS_RST;

    int fail_count = 0;
    int queued_items = 0;
    int cycle_count = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int burst_left = 0;
    int gap_left = 0;
    logic rx_hold_active = 1'b0;

    always #5 clk = ~clk;

    rfid_reply_frame_checker i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 0; k < 8; k++) begin
            fb = c[0] ^ b[k];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void clear_frame_state();
        fr_count  = '0;
        fr_len    = '0;
        fr_crc    = CRC_PRESET;
        fr_cmd    = '0;
        fr_status = '0;
        fr_uid    = '0;
    endfunction

    function automatic bit predict_verdict(input logic restart, input logic [7:0] b,
                                           output t_verdict v);
        logic [8:0] idx;
        t_err       err;
        v = '0;
        if (restart) begin
            clear_frame_state();
            return 1'b0;
        end
        if (fr_count > {1'b0, fr_len}) begin
            return 1'b0;
        end
        idx    = fr_count;
        fr_crc = crc16_step(fr_crc, b);
        if (idx == OFS_LEN) begin
            fr_len = b;
        end else if (idx == OFS_CMD) begin
            fr_cmd = b;
        end else if (idx == OFS_STATUS) begin
            fr_status = b;
        end else if (idx >= OFS_DATA && idx < OFS_UID_END) begin
            fr_uid = {fr_uid[55:0], b};
        end
        if (fr_count < COUNT_MAX) begin
            fr_count = fr_count + 9'd1;
        end
        if (fr_count != {1'b0, fr_len} + 9'd1) begin
            return 1'b0;
        end
        if (fr_cmd != cfg_cmd) begin
            err = ERR_CMD;
        end else if (fr_crc != 16'h0000) begin
            err = ERR_CRC;
        end else begin
            err = ERR_OK;
        end
        v.frame_ok      = (err == ERR_OK);
        v.error_code    = err;
        v.reader_status = fr_status;
        v.status_good   = (err == ERR_OK) && (fr_status == cfg_status);
        v.tag_uid       = fr_uid;
        v.frame_length  = fr_len;
        return 1'b1;
    endfunction

    task automatic push_item(input logic restart, input logic [7:0] b);
        t_in_item item;
        item.restart  = restart;
        item.rx_byte  = b;
        pending_bytes = {pending_bytes, item};
        queued_items++;
    endtask

    // restart, then length/address/command/status/data/CRC; cut > 0 truncates
    task automatic push_frame(input int ndata, input logic [7:0] cmd, input logic [7:0] st,
                              input bit bad_crc, input int cut);
        logic [7:0]  fb[$];
        logic [15:0] c;
        int          n;
        c  = CRC_PRESET;
        fb = {fb, 8'(ndata + 5)};
        fb = {fb, 8'($urandom)};
        fb = {fb, cmd};
        fb = {fb, st};
        repeat (ndata) fb = {fb, 8'($urandom)};
        foreach (fb[i]) c = crc16_step(c, fb[i]);
        fb = {fb, c[7:0]};
        fb = {fb, c[15:8]};
        if (bad_crc) begin
            n = $urandom_range(1, fb.size() - 1);
            fb[n] = fb[n] ^ 8'($urandom_range(1, 255));
        end
        n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
        push_item(1'b1, 8'($urandom));
        for (int i = 0; i < n; i++) push_item(1'b0, fb[i]);
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_verdicts.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] cmd, input logic [7:0] st);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXPECTED_CMD;
        cfg_data  <= cmd;
        @(posedge clk);
        cfg_index <= CFG_SUCCESS_STATUS;
        cfg_data  <= st;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gen_cmd    = cmd;
        gen_status = st;
    endtask

    // input side: bursts with random gaps, no gaps while the receiver holds off
    always @(posedge clk) begin : drive_bytes
        t_in_item nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0 && !rx_hold_active) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                nxt = pending_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.rx_byte;
                s_tuser  <= nxt.restart;
                if (burst_left > 1) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                             : $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // output side: stall modes of its own plus requested long hold-offs
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0 || hold_served < hold_reqs) begin
            if (hold_left == 0) begin
                hold_left   = HOLD_CYCLES;
                hold_served = hold_served + 1;
            end else begin
                hold_left = hold_left - 1;
            end
            m_tready       <= 1'b0;
            rx_hold_active <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left = rx_mode_left - 1;
            end
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) != 0);
                default: m_tready <= ($urandom_range(0, 7) == 0);
            endcase
            rx_hold_active <= 1'b0;
        end
    end

    // register writes and accepted input transactions feed the frame tracker
    always @(posedge clk) begin : track_inputs
        t_verdict v;
        if (!rst_n) begin
            clear_frame_state();
            cfg_cmd    = EXPECTED_CMD_RST;
            cfg_status = SUCCESS_STATUS_RST;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_EXPECTED_CMD) begin
                    cfg_cmd = cfg_data;
                end else begin
                    cfg_status = cfg_data;
                end
            end
            if (s_tvalid && s_tready) begin
                if (predict_verdict(s_tuser[0], s_tdata, v)) begin
                    expected_verdicts = {expected_verdicts, v};
                end
            end
        end
    end

    always @(posedge clk) begin : check_verdicts
        t_verdict got;
        t_verdict want;
        if (rst_n && m_tvalid && m_tready) begin
            got = t_verdict'(m_tdata[83:0]);
            if (expected_verdicts.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected verdict: tdata=%h", m_tdata);
                end
                fail_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (got.frame_ok !== want.frame_ok || got.error_code !== want.error_code ||
                    got.reader_status !== want.reader_status ||
                    got.status_good !== want.status_good || got.tag_uid !== want.tag_uid ||
                    got.frame_length !== want.frame_length || m_tdata[87:84] !== 4'h0) begin
                    if (fail_count < 10) begin
                        $display("verdict mismatch: exp ok=%0d err=%0d st=%h good=%0d uid=%h len=%h",
                                 want.frame_ok, want.error_code, want.reader_status,
                                 want.status_good, want.tag_uid, want.frame_length);
                        $display("                  got ok=%0d err=%0d st=%h good=%0d uid=%h len=%h pad=%h",
                                 got.frame_ok, got.error_code, got.reader_status,
                                 got.status_good, got.tag_uid, got.frame_length, m_tdata[87:84]);
                    end
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int kind;
        int ndata;
        int len;
        int target;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero-length frame before any restart, short frames,
        // a clean frame, ignored trailing bytes, command mismatch over a bad CRC
        push_item(1'b0, 8'h00);
        push_item(1'b1, 8'hFF);
        push_item(1'b0, 8'h02);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h50);
        push_item(1'b1, 8'h00);
        push_item(1'b0, 8'h03);
        push_item(1'b0, 8'h00);
        push_item(1'b0, 8'h50);
        push_item(1'b0, 8'h7F);
        push_frame(0, 8'h50, 8'h00, 1'b0, 0);
        push_item(1'b0, 8'hFF);
        push_item(1'b0, 8'h00);
        push_frame(0, 8'hAF, 8'h00, 1'b1, 0);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                wait_idle();
                case (ph)
                    1: set_config(8'h00, 8'hFF);
                    2: set_config(8'hFF, 8'h00);
                    default: set_config(8'($urandom), 8'($urandom));
                endcase
            end
            if (ph == 1 || ph == 5) begin
                hold_reqs++;
            end
            if (ph == 3) begin
                push_frame(250, gen_cmd, gen_status, 1'b0, 0);
            end
            target = queued_items + PHASE_ITEMS;
            while (queued_items < target) begin
                kind = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: ndata = $urandom_range(0, 8);
                    9:          ndata = $urandom_range(17, 40);
                    default:    ndata = $urandom_range(9, 16);
                endcase
                if (kind < 55) begin
                    push_frame(ndata, gen_cmd, $urandom_range(0, 1) ? gen_status : 8'($urandom),
                               1'b0, 0);
                end else if (kind < 65) begin
                    push_frame(ndata, gen_cmd ^ 8'($urandom_range(1, 255)), 8'($urandom),
                               1'($urandom_range(0, 1)), 0);
                end else if (kind < 75) begin
                    push_frame(ndata, gen_cmd, gen_status, 1'b1, 0);
                end else if (kind < 83) begin
                    len = $urandom_range(0, 4);
                    push_item(1'b1, 8'($urandom));
                    push_item(1'b0, 8'(len));
                    for (int i = 1; i <= len; i++) begin
                        push_item(1'b0, (i == 2 && $urandom_range(0, 1)) ? gen_cmd : 8'($urandom));
                    end
                end else if (kind < 90) begin
                    push_frame(ndata, gen_cmd, gen_status, 1'b0, $urandom_range(1, ndata + 6));
                end else if (kind < 99) begin
                    push_frame(ndata, gen_cmd, gen_status, 1'b0, 0);
                    repeat ($urandom_range(1, 6)) begin
                        push_item(1'b0, 8'($urandom));
                    end
                end else begin
                    push_frame($urandom_range(100, 250), gen_cmd, gen_status,
                               1'($urandom_range(0, 1)), 0);
                end
            end
        end

        wait_idle();
        if (fail_count == 0 && expected_verdicts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
